// ===== rtl/q31mac_pkg.sv =====
// Shared types and constants for the Q31 saturating MAC ALU.
package q31mac_pkg;

  typedef enum logic [2:0] {
    OP_ADD  = 3'd0,
    OP_SUB  = 3'd1,
    OP_MUL  = 3'd2,
    OP_MAC  = 3'd3,
    OP_MSUB = 3'd4,
    OP_LSH  = 3'd5,
    OP_RSH  = 3'd6,
    OP_CLR  = 3'd7
  } op_t;

  localparam logic [31:0] Q31_MAX  = 32'h7fff_ffff;
  localparam logic [31:0] Q31_MIN  = 32'h8000_0000;
  localparam logic [63:0] HALF_LSB = 64'h0000_0000_8000_0000;

  // Item state between the front stage and the accumulate stage
  typedef struct packed {
    op_t         op;
    logic [63:0] wide;        // raw product, or shifted value for right shift
    logic [31:0] direct;      // finished result for saturating ops
    logic        sel_direct;  // take direct instead of the rounded sum
  } stage_t;

endpackage

// ===== rtl/q31mac_front.sv =====
// Front stage: multiplier, saturating add/sub, barrel shifters.
module q31mac_front (
  input  q31mac_pkg::op_t    op,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  input  logic [5:0]         sh,
  output q31mac_pkg::stage_t front
);

  logic signed [63:0] prod;
  logic signed [32:0] sum_ab;
  logic signed [32:0] diff_ab;
  logic signed [63:0] lsh_v;
  logic signed [63:0] rsh_v;
  logic [31:0]        lsh_res;

  function automatic logic [31:0] sat33(input logic signed [32:0] v);
    if (v[32] != v[31]) begin
      return v[32] ? q31mac_pkg::Q31_MIN : q31mac_pkg::Q31_MAX;
    end
    return v[31:0];
  endfunction

  assign prod    = 64'(a) * 64'(b);
  assign sum_ab  = 33'(a) + 33'(b);
  assign diff_ab = 33'(a) - 33'(b);
  assign lsh_v   = 64'(a) <<< sh[4:0];
  assign rsh_v   = $signed({a, 32'h0}) >>> sh;

  always_comb begin
    if (a == '0) begin
      lsh_res = '0;
    end else if (sh[5] || (lsh_v[63:31] != {33{lsh_v[63]}})) begin
      lsh_res = a[31] ? q31mac_pkg::Q31_MIN : q31mac_pkg::Q31_MAX;
    end else begin
      lsh_res = lsh_v[31:0];
    end
  end

  always_comb begin
    front.op         = op;
    front.wide       = (op == q31mac_pkg::OP_RSH) ? rsh_v : prod;
    front.direct     = '0;
    front.sel_direct = 1'b1;
    case (op)
      q31mac_pkg::OP_ADD: begin
        front.direct = sat33(sum_ab);
      end
      q31mac_pkg::OP_SUB: begin
        front.direct = sat33(diff_ab);
      end
      q31mac_pkg::OP_MUL: begin
        // minus one squared would round to the minimum; pin to the maximum
        front.direct     = q31mac_pkg::Q31_MAX;
        front.sel_direct = (a == q31mac_pkg::Q31_MIN) && (b == q31mac_pkg::Q31_MIN);
      end
      q31mac_pkg::OP_MAC, q31mac_pkg::OP_MSUB, q31mac_pkg::OP_RSH: begin
        front.sel_direct = 1'b0;
      end
      q31mac_pkg::OP_LSH: begin
        front.direct = lsh_res;
      end
      default: begin
        front.direct = '0;
      end
    endcase
  end

endmodule

// ===== rtl/q31mac_acc.sv =====
// Accumulate stage: one 64-bit adder for rounding and the biased accumulator.
module q31mac_acc (
  input  logic               clk,
  input  logic               rst,
  input  logic               fire,
  input  q31mac_pkg::stage_t front,
  output logic [31:0]        result_next
);

  // acc holds accumulator + 2^31, so its upper word is the rounded value
  logic [63:0] acc;
  logic [63:0] acc_next;
  logic [63:0] dbl;
  logic [63:0] base;
  logic [63:0] addend;
  logic        cin;
  logic [63:0] sum;

  assign dbl = {front.wide[62:0], 1'b0};

  always_comb begin
    base   = q31mac_pkg::HALF_LSB;
    addend = dbl;
    cin    = 1'b0;
    case (front.op)
      q31mac_pkg::OP_MAC: begin
        base = acc;
      end
      q31mac_pkg::OP_MSUB: begin
        base   = acc;
        addend = ~dbl;
        cin    = 1'b1;
      end
      q31mac_pkg::OP_RSH: begin
        addend = front.wide;
      end
      default: begin
        addend = dbl;
      end
    endcase
  end

  assign sum         = base + addend + {63'h0, cin};
  assign result_next = front.sel_direct ? front.direct : sum[63:32];

  always_comb begin
    acc_next = acc;
    case (front.op)
      q31mac_pkg::OP_MAC, q31mac_pkg::OP_MSUB: acc_next = sum;
      q31mac_pkg::OP_CLR:                      acc_next = q31mac_pkg::HALF_LSB;
      default:                                 acc_next = acc;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= q31mac_pkg::HALF_LSB;
    end else if (fire) begin
      acc <= acc_next;
    end
  end

endmodule

// ===== rtl/q31_saturating_mac_alu.sv =====
// Q31 saturating MAC ALU: top level with item pipeline and flow control.
// Registers in order: input reg, product reg, result reg. Throughput: one
// item per cycle while the output is not stalled, set by the
// single 32x32 multiplier stage and the one-add accumulator loop.
// Reset (rst, synchronous, active high) empties the pipe and sets the
// accumulator to zero.
module q31_saturating_mac_alu (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  logic [2:0]         req_type,
  input  logic signed [31:0] operand_a,
  input  logic signed [31:0] operand_b,
  input  logic [5:0]         shift_amount,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output logic signed [31:0] result
);

  // Stage 1: registered item
  logic               s1_valid;
  q31mac_pkg::op_t    s1_op;
  logic signed [31:0] s1_a;
  logic signed [31:0] s1_b;
  logic [5:0]         s1_sh;

  // Stage 2: registered product / partial results
  logic               s2_valid;
  q31mac_pkg::stage_t s2;
  q31mac_pkg::stage_t s2_next;

  logic [31:0] result_next;

  // Load enables: a stage loads when empty or when its item moves on.
  // Each stage holds at most one item, so with a bubble anywhere in the
  // pipe the input side keeps taking items while the output is stalled.
  logic ld3;
  logic ld2;
  logic ld1;
  logic fire2;

  assign ld3       = !rsp_valid || !rsp_stall;
  assign ld2       = !s2_valid || ld3;
  assign ld1       = !s1_valid || ld2;
  assign req_stall = !ld1;
  // stage-2 item leaves this cycle: the accumulator commits exactly once
  assign fire2     = s2_valid && ld3;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (ld1) begin
      s1_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ld1 && req_valid) begin
      s1_op <= q31mac_pkg::op_t'(req_type);
      s1_a  <= operand_a;
      s1_b  <= operand_b;
      s1_sh <= shift_amount;
    end
  end

  q31mac_front u_front (
    .op    (s1_op),
    .a     (s1_a),
    .b     (s1_b),
    .sh    (s1_sh),
    .front (s2_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (ld2) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ld2 && s1_valid) begin
      s2 <= s2_next;
    end
  end

  // Accumulate / round stage feeding the result register
  q31mac_acc u_acc (
    .clk         (clk),
    .rst         (rst),
    .fire        (fire2),
    .front       (s2),
    .result_next (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (ld3) begin
      rsp_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire2) begin
      result <= result_next;
    end
  end

  // Input is held off only when every stage is full and the output is stalled
  assert property (@(posedge clk) disable iff (rst)
    req_stall |-> (s1_valid && s2_valid && rsp_valid && rsp_stall))
    else $error("input stalled with room in the pipe");

  // A multiply takes the direct path only for min times min, and then gives the maximum
  assert property (@(posedge clk) disable iff (rst)
    (s2_valid && (s2.op == q31mac_pkg::OP_MUL) && s2.sel_direct)
      |-> (s2.direct == q31mac_pkg::Q31_MAX))
    else $error("multiply override does not give the maximum");

  // Reset empties the whole pipe
  assert property (@(posedge clk)
    rst |=> (!s1_valid && !s2_valid && !rsp_valid))
    else $error("pipe not empty after reset");

endmodule

// ===== sim/tb_q31_saturating_mac_alu.sv =====
// Self-checking testbench for the Q31 saturating MAC ALU: directed corners, then random items.
`timescale 1ns / 100ps

module tb_q31_saturating_mac_alu;

  localparam logic signed [63:0] SAT_HI = 64'sd2147483647;
  localparam logic signed [63:0] SAT_LO = -64'sd2147483648;
  localparam int RANDOM_ITEMS = 1525;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               req_valid = 1'b0;
  logic               req_stall;
  q31mac_pkg::op_t    req_type = q31mac_pkg::OP_ADD;
  logic signed [31:0] operand_a = '0;
  logic signed [31:0] operand_b = '0;
  logic [5:0]         shift_amount = '0;
  logic               rsp_valid;
  logic               rsp_stall = 1'b0;
  logic signed [31:0] result;

  // Predictor state: a private copy of the 64-bit accumulator
  logic [63:0] acc_model;
  logic [31:0] expected_results[$];
  int          err_count = 0;

  q31_saturating_mac_alu dut (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .req_type     (req_type),
    .operand_a    (operand_a),
    .operand_b    (operand_b),
    .shift_amount (shift_amount),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .result       (result)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Generous watchdog; a correct run takes a small fraction of this
  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  task automatic report(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    err_count++;
  endtask

  function automatic logic [31:0] sat_q31(input logic signed [63:0] v);
    if (v > SAT_HI) return q31mac_pkg::Q31_MAX;
    if (v < SAT_LO) return q31mac_pkg::Q31_MIN;
    return v[31:0];
  endfunction

  // Upper word of x + 2^31, modulo 2^64
  function automatic logic [31:0] round_upper(input logic [63:0] x);
    logic [63:0] s;
    s = x + q31mac_pkg::HALF_LSB;
    return s[63:32];
  endfunction

  // Expected Q31 result of one item; updates the accumulator copy
  function automatic logic [31:0] q31_predict(input q31mac_pkg::op_t op,
                                              input logic signed [31:0] a,
                                              input logic signed [31:0] b,
                                              input logic [5:0] sh);
    logic signed [63:0] a64;
    logic signed [63:0] b64;
    logic signed [63:0] prod2;
    logic signed [63:0] wide;
    logic [31:0]        r;
    a64   = 64'(a);
    b64   = 64'(b);
    prod2 = (a64 * b64) <<< 1;
    r     = '0;
    case (op)
      q31mac_pkg::OP_ADD:  r = sat_q31(a64 + b64);
      q31mac_pkg::OP_SUB:  r = sat_q31(a64 - b64);
      q31mac_pkg::OP_MUL: begin
        if (a == q31mac_pkg::Q31_MIN && b == q31mac_pkg::Q31_MIN) r = q31mac_pkg::Q31_MAX;
        else r = round_upper(prod2);
      end
      q31mac_pkg::OP_MAC: begin
        acc_model = acc_model + prod2;
        r = round_upper(acc_model);
      end
      q31mac_pkg::OP_MSUB: begin
        acc_model = acc_model - prod2;
        r = round_upper(acc_model);
      end
      q31mac_pkg::OP_LSH: begin
        if (a == 0) r = '0;
        else if (sh >= 6'd32) r = a[31] ? q31mac_pkg::Q31_MIN : q31mac_pkg::Q31_MAX;
        else r = sat_q31(a64 <<< sh);
      end
      q31mac_pkg::OP_RSH: begin
        // operand in the upper word, low word zero
        wide = {a, 32'h0};
        wide = wide >>> sh;
        r = round_upper(wide);
      end
      default: begin
        acc_model = '0;
        r = '0;
      end
    endcase
    return r;
  endfunction

  // Present one item at the falling edge, hold it until taken, then predict
  task automatic send_item(input q31mac_pkg::op_t op, input logic [31:0] a,
                           input logic [31:0] b, input logic [5:0] sh);
    @(negedge clk);
    req_valid    <= 1'b1;
    req_type     <= op;
    operand_a    <= a;
    operand_b    <= b;
    shift_amount <= sh;
    do @(posedge clk); while (req_stall);
    expected_results.push_back(q31_predict(op, a, b, sh));
  endtask

  // Receiver back-pressure: the stall rate is redrawn at the start of each window,
  // with a zero rate among the choices so some stretches run free
  initial begin
    int pct;
    int window;
    pct    = 0;
    window = 0;
    forever begin
      @(negedge clk);
      if (window == 0) begin
        case ($urandom_range(0, 3))
          0: pct = 0;
          1: pct = 20;
          2: pct = 50;
          default: pct = 85;
        endcase
        window = 64;
      end
      window--;
      rsp_stall <= ($urandom_range(0, 99) < pct);
    end
  end

  // Result checker: every taken result against the oldest expectation
  always @(posedge clk) begin
    logic [31:0] want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_results.size() == 0) begin
        report($sformatf("result %h with no item pending", result));
      end else begin
        want = expected_results.pop_front();
        if (result !== want)
          report($sformatf("result got %h want %h", result, want));
      end
    end
  end

  task automatic test_add_sub_saturation();
    send_item(q31mac_pkg::OP_ADD, q31mac_pkg::Q31_MAX, 32'h0000_0001, 6'($urandom));
    send_item(q31mac_pkg::OP_ADD, q31mac_pkg::Q31_MIN, 32'hffff_ffff, 6'($urandom));
    send_item(q31mac_pkg::OP_ADD, q31mac_pkg::Q31_MAX, q31mac_pkg::Q31_MIN, 6'($urandom));
    send_item(q31mac_pkg::OP_SUB, q31mac_pkg::Q31_MIN, 32'h0000_0001, 6'($urandom));
    send_item(q31mac_pkg::OP_SUB, q31mac_pkg::Q31_MAX, 32'hffff_ffff, 6'($urandom));
    send_item(q31mac_pkg::OP_SUB, q31mac_pkg::Q31_MIN, q31mac_pkg::Q31_MIN, 6'($urandom));
  endtask

  task automatic test_multiply();
    // min times min must saturate to the maximum
    send_item(q31mac_pkg::OP_MUL, q31mac_pkg::Q31_MIN, q31mac_pkg::Q31_MIN, 6'($urandom));
    send_item(q31mac_pkg::OP_MUL, q31mac_pkg::Q31_MIN, q31mac_pkg::Q31_MAX, 6'($urandom));
    send_item(q31mac_pkg::OP_MUL, q31mac_pkg::Q31_MAX, q31mac_pkg::Q31_MAX, 6'($urandom));
    send_item(q31mac_pkg::OP_MUL, 32'h4000_0000, 32'hffff_ffff, 6'($urandom));
  endtask

  task automatic test_accumulate_wrap();
    send_item(q31mac_pkg::OP_CLR, $urandom, $urandom, 6'($urandom));
    // doubled min*min is 2^63: the accumulator wraps, no saturation
    send_item(q31mac_pkg::OP_MAC, q31mac_pkg::Q31_MIN, q31mac_pkg::Q31_MIN, 6'($urandom));
    send_item(q31mac_pkg::OP_MAC, q31mac_pkg::Q31_MIN, q31mac_pkg::Q31_MIN, 6'($urandom));
    send_item(q31mac_pkg::OP_MSUB, q31mac_pkg::Q31_MAX, q31mac_pkg::Q31_MAX, 6'($urandom));
    send_item(q31mac_pkg::OP_MSUB, q31mac_pkg::Q31_MIN, q31mac_pkg::Q31_MAX, 6'($urandom));
    send_item(q31mac_pkg::OP_CLR, $urandom, $urandom, 6'($urandom));
  endtask

  task automatic test_shifts();
    send_item(q31mac_pkg::OP_LSH, 32'h0, $urandom, 6'd63);
    send_item(q31mac_pkg::OP_LSH, 32'h1, $urandom, 6'd30);
    send_item(q31mac_pkg::OP_LSH, 32'h1, $urandom, 6'd31);
    send_item(q31mac_pkg::OP_LSH, 32'hffff_ffff, $urandom, 6'd31);
    send_item(q31mac_pkg::OP_LSH, 32'hffff_fffe, $urandom, 6'd31);
    send_item(q31mac_pkg::OP_LSH, 32'h5, $urandom, 6'd32);
    send_item(q31mac_pkg::OP_RSH, q31mac_pkg::Q31_MIN, $urandom, 6'd63);
    send_item(q31mac_pkg::OP_RSH, 32'hffff_ffff, $urandom, 6'd32);
    send_item(q31mac_pkg::OP_RSH, q31mac_pkg::Q31_MAX, $urandom, 6'd0);
  endtask

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(0, 9))
      0:       return q31mac_pkg::Q31_MAX;
      1:       return q31mac_pkg::Q31_MIN;
      2:       return 32'h0;
      3:       return $urandom_range(0, 1) ? 32'h1 : 32'hffff_ffff;
      4:       return $urandom_range(0, 255) - 128;
      default: return $urandom;
    endcase
  endfunction

  // Random items in bursts; mac/msub weighted so the accumulator wraps often
  task automatic test_random(input int count);
    int              burst;
    int              pick;
    q31mac_pkg::op_t op;
    logic [5:0]      sh;
    burst = 0;
    for (int i = 0; i < count; i++) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 40);
        if ($urandom_range(0, 3) != 0) begin
          repeat ($urandom_range(1, 8)) begin
            @(negedge clk);
            req_valid <= 1'b0;
          end
        end
      end
      burst--;
      pick = $urandom_range(0, 99);
      if (pick < 12)      op = q31mac_pkg::OP_ADD;
      else if (pick < 24) op = q31mac_pkg::OP_SUB;
      else if (pick < 38) op = q31mac_pkg::OP_MUL;
      else if (pick < 58) op = q31mac_pkg::OP_MAC;
      else if (pick < 72) op = q31mac_pkg::OP_MSUB;
      else if (pick < 84) op = q31mac_pkg::OP_LSH;
      else if (pick < 96) op = q31mac_pkg::OP_RSH;
      else                op = q31mac_pkg::OP_CLR;
      sh = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(28, 36))
                                       : 6'($urandom_range(0, 63));
      send_item(op, rand_operand(), rand_operand(), sh);
    end
  endtask

  initial begin
    acc_model = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_add_sub_saturation();
    test_multiply();
    test_accumulate_wrap();
    test_shifts();
    test_random(RANDOM_ITEMS);

    @(negedge clk);
    req_valid <= 1'b0;

    // drain, then wait on to catch any stray result
    for (int n = 0; n < 20000 && expected_results.size() != 0; n++) @(posedge clk);
    repeat (10) @(posedge clk);
    if (expected_results.size() != 0)
      report($sformatf("%0d results never arrived", expected_results.size()));

    if (err_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
